@@ src/cmfd_pkg.sv @@
// Shared types, constants and state codes for the motion and fall detector.
package cmfd_pkg;

    localparam int TimeBits  = 48;
    localparam int FracBits  = 8;
    localparam int MagBits   = 16;
    localparam int BaseBits  = 32;
    localparam int DeltaBits = 23;
    localparam int ConfBits  = 9;
    localparam int CfgBits   = 16;
    localparam int CfgIdxBits = 3;

    // divider geometry
    localparam int DivNumBits = 48;
    localparam int DivDenBits = 32;

    localparam logic [DeltaBits-1:0] DeltaMax     = '1;
    localparam logic [TimeBits-1:0]  FallCoolUs   = 48'd15000000;
    localparam logic [TimeBits-1:0]  MotionCoolUs = 48'd3000000;
    localparam logic [ConfBits-1:0]  ConfOne      = 9'd256;
    // 1.0 in baseline scale (F+16 fraction bits)
    localparam logic [BaseBits-1:0]  BaseOne      = 32'h0100_0000;

    // configuration register indexes
    localparam logic [CfgIdxBits-1:0] RegCalPackets = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegMotionPct  = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegFallPct    = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegMotionCons = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegFallCons   = 3'd4;

    typedef struct packed {
        logic [MagBits-1:0]  magnitude;
        logic [TimeBits-1:0] timestamp_us;
    } t_in_word;

    typedef struct packed {
        logic                 event_kind;
        logic [DeltaBits-1:0] event_value;
        logic [ConfBits-1:0]  confidence;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CAL_WAIT,
        ST_DEV_WAIT,
        ST_DRIFT_WAIT,
        ST_EVENT,
        ST_CONF_WAIT,
        ST_EMIT
    } t_state;

endpackage

@@ src/csi_motion_fall_detector_unit.sv @@
// Top level of the channel-magnitude motion and fall detector.
//
//  channel | handshake               | word
//  in      | i_in_valid / o_in_ready | i_in_word (magnitude, timestamp_us)
//  out     | o_out_valid/ i_out_ready| o_out_word (event_kind, event_value, confidence)
//  cfg     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A word needs no division for the first calibration sample, one for other
// calibration samples and one to three after calibration; each division holds
// the one shared bit-serial divider until it is done.
// Reset is synchronous, active low; it clears the detector state and loads defaults.
// The result sits in an output register; the next word is taken while it waits,
// and the sequencer stalls only if a second event is ready before it is taken.
module csi_motion_fall_detector_unit import cmfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_idx,
    input  logic [CfgBits-1:0]    i_cfg_data
);

    // configuration
    logic [15:0] r_cal_packets;
    logic [9:0]  r_motion_pct;
    logic [9:0]  r_fall_pct;
    logic [7:0]  r_motion_cons;
    logic [7:0]  r_fall_cons;

    // detector state
    t_state               r_state, n_state;
    logic [BaseBits-1:0]  r_base, n_base;
    logic [DeltaBits-1:0] r_smooth, n_smooth;
    logic [15:0]          r_seen, n_seen;
    logic [7:0]           r_fall_run, n_fall_run;
    logic [7:0]           r_motion_run, n_motion_run;
    logic [TimeBits-1:0]  r_last_fall, n_last_fall;
    logic [TimeBits-1:0]  r_last_motion, n_last_motion;

    // per-word working registers
    logic [MagBits-1:0]   r_mag, n_mag;
    logic [TimeBits-1:0]  r_now, n_now;
    logic                 r_hit, n_hit;
    logic                 r_kind, n_kind;
    logic [ConfBits-1:0]  r_conf, n_conf;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out, n_out;

    // divider launch
    logic                  r_div_start, n_div_start;
    logic [DivNumBits-1:0] r_div_num, n_div_num;
    logic [DivDenBits-1:0] r_div_den, n_div_den;
    logic                  div_done;
    logic [DivNumBits-1:0] div_quot;

    // datapath helpers
    logic [BaseBits-1:0]  mag_wide;
    logic [BaseBits-1:0]  diff;
    logic [BaseBits-1:0]  denom;
    logic [DeltaBits-1:0] dev;
    logic [DeltaBits-1:0] smooth_new;
    logic [DeltaBits+2:0] smooth_sum;
    logic [17:0]          motion_thr;
    logic [17:0]          fall_thr;
    logic [7:0]           fall_run_new;
    logic [7:0]           motion_run_new;
    logic [TimeBits-1:0]  fall_elapsed;
    logic [TimeBits-1:0]  motion_elapsed;
    logic                 fall_evt;
    logic                 motion_evt;
    logic [9:0]           evt_pct;

    cmfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_packets <= 16'd100;
            r_motion_pct  <= 10'd20;
            r_fall_pct    <= 10'd50;
            r_motion_cons <= 8'd3;
            r_fall_cons   <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegCalPackets: r_cal_packets <= i_cfg_data;
                RegMotionPct:  r_motion_pct  <= i_cfg_data[9:0];
                RegFallPct:    r_fall_pct    <= i_cfg_data[9:0];
                RegMotionCons: r_motion_cons <= i_cfg_data[7:0];
                RegFallCons:   r_fall_cons   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_base        <= '0;
            r_smooth      <= '0;
            r_seen        <= '0;
            r_fall_run    <= '0;
            r_motion_run  <= '0;
            r_last_fall   <= '0;
            r_last_motion <= '0;
            r_out_valid   <= 1'b0;
            r_div_start   <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_base        <= n_base;
            r_smooth      <= n_smooth;
            r_seen        <= n_seen;
            r_fall_run    <= n_fall_run;
            r_motion_run  <= n_motion_run;
            r_last_fall   <= n_last_fall;
            r_last_motion <= n_last_motion;
            r_out_valid   <= n_out_valid;
            r_div_start   <= n_div_start;
            r_hit         <= n_hit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_now     <= n_now;
        r_kind    <= n_kind;
        r_conf    <= n_conf;
        r_out     <= n_out;
        r_div_num <= n_div_num;
        r_div_den <= n_div_den;
    end

    // deviation and streak datapath
    always_comb begin
        mag_wide = {r_mag, 16'b0};
        diff     = (mag_wide >= r_base) ? mag_wide - r_base : r_base - mag_wide;
        denom    = (r_base > BaseOne) ? r_base : BaseOne;
        dev      = (div_quot[DivNumBits-1:DeltaBits] != '0) ? DeltaMax
                                                            : div_quot[DeltaBits-1:0];
        smooth_sum = (DeltaBits+3)'(3) * {3'b0, r_smooth} + {3'b0, dev} + (DeltaBits+3)'(2);
        smooth_new = (r_smooth == '0) ? dev : smooth_sum[DeltaBits+1:2];
        motion_thr = {r_motion_pct, 8'b0};
        fall_thr   = {r_fall_pct, 8'b0};
        fall_run_new = ({5'b0, smooth_new} >= {5'b0, fall_thr}) ?
                       ((r_fall_run == 8'hFF) ? 8'hFF : r_fall_run + 8'd1) : 8'd0;
        motion_run_new = ({5'b0, smooth_new} >= {5'b0, motion_thr}) ?
                         ((r_motion_run == 8'hFF) ? 8'hFF : r_motion_run + 8'd1) : 8'd0;
        fall_elapsed   = r_now - r_last_fall;
        motion_elapsed = r_now - r_last_motion;
        fall_evt   = (fall_run_new >= r_fall_cons) && (fall_elapsed > FallCoolUs);
        motion_evt = (motion_run_new >= r_motion_cons) && (motion_elapsed > MotionCoolUs);
        evt_pct    = r_kind ? r_fall_pct : r_motion_pct;
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_base        = r_base;
        n_smooth      = r_smooth;
        n_seen        = r_seen;
        n_fall_run    = r_fall_run;
        n_motion_run  = r_motion_run;
        n_last_fall   = r_last_fall;
        n_last_motion = r_last_motion;
        n_mag         = r_mag;
        n_now         = r_now;
        n_hit         = r_hit;
        n_kind        = r_kind;
        n_conf        = r_conf;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_div_start   = 1'b0;
        n_div_num     = r_div_num;
        n_div_den     = r_div_den;
        o_in_ready    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mag   = i_in_word.magnitude;
                    n_now   = i_in_word.timestamp_us;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_seen < r_cal_packets) begin
                    n_seen = r_seen + 16'd1;
                    if (r_seen == '0) begin
                        n_base  = mag_wide;
                        n_state = ST_IDLE;
                    end else begin
                        n_div_num = DivNumBits'(r_base) * DivNumBits'(49)
                                  + DivNumBits'(mag_wide) + DivNumBits'(25);
                        n_div_den   = DivDenBits'(50);
                        n_div_start = 1'b1;
                        n_state     = ST_CAL_WAIT;
                    end
                end else begin
                    n_div_num   = {40'(diff) * 40'd100, 8'b0};
                    n_div_den   = denom;
                    n_div_start = 1'b1;
                    n_state     = ST_DEV_WAIT;
                end
            end
            ST_CAL_WAIT: begin
                if (div_done) begin
                    n_base  = div_quot[BaseBits-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_DEV_WAIT: begin
                if (div_done) begin
                    n_smooth     = smooth_new;
                    n_fall_run   = fall_run_new;
                    n_motion_run = motion_run_new;
                    n_hit        = 1'b0;
                    if (fall_evt) begin
                        n_hit        = 1'b1;
                        n_kind       = 1'b1;
                        n_last_fall  = r_now;
                        n_fall_run   = '0;
                        n_motion_run = '0;
                    end else if (motion_evt) begin
                        n_hit         = 1'b1;
                        n_kind        = 1'b0;
                        n_last_motion = r_now;
                        n_motion_run  = '0;
                    end
                    // baseline drifts only while quiet
                    if ({5'b0, smooth_new} < {5'b0, motion_thr}) begin
                        n_div_num = DivNumBits'(r_base) * DivNumBits'(997)
                                  + DivNumBits'(mag_wide) * DivNumBits'(3)
                                  + DivNumBits'(500);
                        n_div_den   = DivDenBits'(1000);
                        n_div_start = 1'b1;
                        n_state     = ST_DRIFT_WAIT;
                    end else begin
                        n_state = ST_EVENT;
                    end
                end
            end
            ST_DRIFT_WAIT: begin
                if (div_done) begin
                    n_base  = div_quot[BaseBits-1:0];
                    n_state = ST_EVENT;
                end
            end
            ST_EVENT: begin
                if (!r_hit) begin
                    n_state = ST_IDLE;
                end else if (evt_pct == '0) begin
                    n_conf  = ConfOne;
                    n_state = ST_EMIT;
                end else begin
                    if (r_kind) begin
                        n_div_num = {16'b0, r_smooth, 9'b0};
                        n_div_den = {12'b0, 12'(evt_pct) * 12'd3, 8'b0};
                    end else begin
                        n_div_num = {18'b0, r_smooth, 7'b0};
                        n_div_den = {14'b0, evt_pct, 8'b0};
                    end
                    n_div_start = 1'b1;
                    n_state     = ST_CONF_WAIT;
                end
            end
            ST_CONF_WAIT: begin
                if (div_done) begin
                    n_conf  = (div_quot > DivNumBits'(ConfOne)) ? ConfOne
                                                                : div_quot[ConfBits-1:0];
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.event_kind  = r_kind;
                    n_out.event_value = r_smooth;
                    n_out.confidence  = r_conf;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    // confidence is capped at one
    a_conf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.confidence <= ConfOne))
        else $error("confidence above cap");

    // divider start is only seen while the sequencer waits on it
    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == ST_CAL_WAIT || r_state == ST_DEV_WAIT ||
                         r_state == ST_DRIFT_WAIT || r_state == ST_CONF_WAIT))
        else $error("divider started outside a wait state");

    // an accepted word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");
`endif

endmodule

@@ src/cmfd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module cmfd_div import cmfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DivNumBits-1:0] i_num,
    input  logic [DivDenBits-1:0] i_den,
    output logic                  o_done,
    output logic [DivNumBits-1:0] o_quot
);

    localparam int CntBits = $clog2(DivNumBits + 1);

    logic [DivNumBits-1:0] r_num;
    logic [DivDenBits-1:0] r_den;
    logic [DivDenBits-1:0] r_rem;
    logic [CntBits-1:0]    r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DivDenBits:0]   trial;
    logic                  fits;

    // trial subtract of the next partial remainder
    assign trial = {r_rem, r_num[DivNumBits-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? DivDenBits'(trial - {1'b0, r_den})
                              : trial[DivDenBits-1:0];
                r_num <= {r_num[DivNumBits-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntBits'(DivNumBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
